/* design/graph_conv_layer_macros.svh */
// ---------------------------------------------------------------------------
// graph conv layer assertion macros
// shared property shorthands for the checker
// ---------------------------------------------------------------------------
`ifndef GRAPH_CONV_LAYER_MACROS_SVH
`define GRAPH_CONV_LAYER_MACROS_SVH

// same-cycle implication, muted during reset
`define GCL_ASSERT_IMP(lbl, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");

// next-cycle implication, muted during reset
`define GCL_ASSERT_NXT(lbl, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");

// next-cycle implication that also holds across reset
`define GCL_ASSERT_ALW(lbl, a, c) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) else $error("lbl");

`endif

/* design/gcl_pkg.sv */
// ---------------------------------------------------------------------------
// gcl_pkg
// shared constants, types and helpers of the graph convolution layer
// ---------------------------------------------------------------------------
package gcl_pkg;

  localparam int NODE_CAP  = 64;
  localparam int EDGE_CAP  = 512;
  localparam int IN_W      = 16;
  localparam int OUT_W     = 16;

  localparam int NODE_BITS = $clog2(NODE_CAP);
  localparam int EDGE_BITS = $clog2(EDGE_CAP);
  localparam int RP_DEPTH  = NODE_CAP + 1;
  localparam int ROOT_ONE  = 32'h4000_0000;

  typedef enum logic [2:0] {
    CMD_FEATURE   = 3'd0,
    CMD_WEIGHT    = 3'd1,
    CMD_BIAS      = 3'd2,
    CMD_ROW_PTR   = 3'd3,
    CMD_COL_IDX   = 3'd4,
    CMD_TRANSFORM = 3'd5,
    CMD_AGGREGATE = 3'd6,
    CMD_NONE      = 3'd7
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE, S_TMAC, S_TRP0, S_TRP1, S_TRP2, S_TSQ,
    S_ARP0, S_ARP1, S_ARP2, S_AEDGE, S_ACOL, S_AINV, S_AMAC, S_AOUT
  } state_t;

  typedef struct packed {
    logic        feat_we;
    logic [9:0]  feat_addr;
    logic [15:0] feat_wd;
    logic        wt_we;
    logic [7:0]  wt_addr;
    logic [15:0] wt_wd;
    logic        bias_we;
    logic [3:0]  bias_addr;
    logic [15:0] bias_wd;
    logic        rp_we;
    logic [6:0]  rp_addr;
    logic [9:0]  rp_wd;
    logic        col_we;
    logic [8:0]  col_addr;
    logic [5:0]  col_wd;
    logic        tr_we;
    logic [9:0]  tr_addr;
    logic [15:0] tr_wd;
    logic        inv_we;
    logic [5:0]  inv_addr;
    logic [15:0] inv_wd;
  } mem_req_t;

  typedef struct packed {
    logic [15:0] feat;
    logic [15:0] wt;
    logic [15:0] bias;
    logic [9:0]  rp;
    logic [5:0]  col;
    logic [15:0] tr;
    logic [15:0] inv;
  } mem_rsp_t;

  function automatic logic [15:0] sat16(input logic signed [27:0] v);
    logic [15:0] r;
    if (v > 28'sd32767) r = 16'h7fff;
    else if (v < -28'sd32768) r = 16'h8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

/* design/gcl_store.sv */
// ---------------------------------------------------------------------------
// gcl_store
// feature, weight, bias, graph, transformed row and norm memories
// ---------------------------------------------------------------------------
module gcl_store (
  input  logic              clk,
  input  gcl_pkg::mem_req_t req,
  output gcl_pkg::mem_rsp_t rsp
);
  import gcl_pkg::*;

  logic [15:0] feat_mem [0:NODE_CAP*IN_W-1];
  logic [15:0] wt_mem   [0:IN_W*OUT_W-1];
  logic [15:0] bias_mem [0:OUT_W-1];
  logic [9:0]  rp_mem   [0:RP_DEPTH-1];
  logic [5:0]  col_mem  [0:EDGE_CAP-1];
  logic [15:0] tr_mem   [0:NODE_CAP*OUT_W-1];
  logic [15:0] inv_mem  [0:NODE_CAP-1];

  always_ff @(posedge clk) begin
    if (req.feat_we) feat_mem[req.feat_addr] <= req.feat_wd;
    rsp.feat <= feat_mem[req.feat_addr];
    if (req.wt_we) wt_mem[req.wt_addr] <= req.wt_wd;
    rsp.wt <= wt_mem[req.wt_addr];
    if (req.bias_we) bias_mem[req.bias_addr] <= req.bias_wd;
    rsp.bias <= bias_mem[req.bias_addr];
    if (req.rp_we) rp_mem[req.rp_addr] <= req.rp_wd;
    rsp.rp <= rp_mem[req.rp_addr];
    if (req.col_we) col_mem[req.col_addr] <= req.col_wd;
    rsp.col <= col_mem[req.col_addr];
    if (req.tr_we) tr_mem[req.tr_addr] <= req.tr_wd;
    rsp.tr <= tr_mem[req.tr_addr];
    if (req.inv_we) inv_mem[req.inv_addr] <= req.inv_wd;
    rsp.inv <= inv_mem[req.inv_addr];
  end

endmodule

/* design/gcl_isqrt.sv */
// ---------------------------------------------------------------------------
// gcl_isqrt
// inverse root of a degree, floor(32768/sqrt(deg)), one result bit per square and compare
// ---------------------------------------------------------------------------
module gcl_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [9:0]  deg,
  output logic        done,
  output logic [15:0] root
);
  import gcl_pkg::*;

  logic        run;
  logic        phase;
  logic [3:0]  bitpos;
  logic [9:0]  deg_r;
  logic [31:0] sq;
  logic [15:0] trial;
  logic [41:0] prod;

  assign trial = root | (16'd1 << bitpos);
  assign prod  = sq * 42'(deg_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run    <= (deg != 10'd0);
        done   <= (deg == 10'd0);
        phase  <= 1'b0;
        bitpos <= 4'd15;
        deg_r  <= deg;
        root   <= 16'd0;
      end else if (run) begin
        phase <= ~phase;
        if (!phase) begin
          sq <= trial * trial;
        end else begin
          if (prod <= 42'(ROOT_ONE)) root <= trial;
          bitpos <= bitpos - 4'd1;
          if (bitpos == 4'd0) begin
            run  <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

endmodule

/* design/gcl_ctrl.sv */
// ---------------------------------------------------------------------------
// gcl_ctrl
// command decode and sequencer for transform and aggregate over the memories
// ---------------------------------------------------------------------------
module gcl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        command,
  input  logic [6:0]        node,
  input  logic [3:0]        in_feature,
  input  logic [3:0]        out_feature,
  input  logic [15:0]       value,
  input  logic [8:0]        edge_position,
  input  logic [5:0]        neighbour,
  input  logic [9:0]        edge_offset,
  input  logic              cfg_valid,
  input  logic [6:0]        cfg_data,
  output gcl_pkg::mem_req_t req,
  input  gcl_pkg::mem_rsp_t rsp,
  output logic              sq_start,
  output logic [9:0]        sq_deg,
  input  logic              sq_done,
  input  logic [15:0]       sq_root,
  output logic              out_valid,
  output logic [5:0]        out_node,
  output logic [3:0]        out_index,
  output logic [15:0]       out_value,
  output logic              last
);
  import gcl_pkg::*;

  state_t state, state_next;
  logic [6:0]  node_count;
  logic [5:0]  node_r;
  logic [4:0]  cnt;
  logic [3:0]  o_cnt;
  logic        pend;
  logic [3:0]  pend_k;
  logic signed [27:0] acc_t;
  logic [9:0]  s_ptr, e_ptr, p_ptr;
  logic [15:0] inv_i;
  logic [5:0]  j_r;
  logic [16:0] coef;
  logic signed [25:0] acc_a [0:OUT_W-1];

  logic        accept, node_ok, row_done, edge_ok;
  logic signed [31:0] prod_t;
  logic signed [27:0] sum_t;
  logic signed [33:0] prod_a;
  logic [31:0] coef_full;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign node_ok  = (node < node_count) && (node < 7'(NODE_CAP));
  assign row_done = pend && (pend_k == 4'(OUT_W - 1));
  assign edge_ok  = (p_ptr < e_ptr) && (p_ptr < 10'(EDGE_CAP));

  // transform datapath: truncated product plus bias or running sum
  assign prod_t = $signed(rsp.feat) * $signed(rsp.wt);
  assign sum_t  = ((pend_k == 4'd0) ? 28'(signed'(rsp.bias)) : acc_t)
                + 28'(signed'(prod_t[31:8]));
  // aggregate datapath: coefficient times transformed value
  assign prod_a    = $signed({1'b0, coef}) * $signed(rsp.tr);
  assign coef_full = inv_i * rsp.inv;
  assign sq_deg    = (rsp.rp > s_ptr) ? (rsp.rp - s_ptr) : 10'd0;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && node_ok && command == CMD_TRANSFORM) state_next = S_TMAC;
        else if (accept && node_ok && command == CMD_AGGREGATE) state_next = S_ARP0;
      end
      S_TMAC:  if (row_done && o_cnt == 4'(OUT_W - 1)) state_next = S_TRP0;
      S_TRP0:  state_next = S_TRP1;
      S_TRP1:  state_next = S_TRP2;
      S_TRP2:  state_next = S_TSQ;
      S_TSQ:   if (sq_done) state_next = S_IDLE;
      S_ARP0:  state_next = S_ARP1;
      S_ARP1:  state_next = S_ARP2;
      S_ARP2:  state_next = S_AEDGE;
      S_AEDGE: state_next = edge_ok ? S_ACOL : S_AOUT;
      S_ACOL:  state_next = S_AINV;
      S_AINV:  state_next = S_AMAC;
      S_AMAC:  if (row_done) state_next = S_AEDGE;
      S_AOUT:  if (o_cnt == 4'(OUT_W - 1)) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req = '0;
    req.feat_addr = {node_r, cnt[3:0]};
    req.wt_addr   = {cnt[3:0], o_cnt};
    req.bias_addr = o_cnt;
    req.tr_addr   = {node_r, o_cnt};
    req.tr_wd     = sat16(sum_t);
    req.inv_addr  = node_r;
    req.inv_wd    = sq_root;
    req.col_addr  = p_ptr[8:0];
    req.rp_addr   = {1'b0, node_r};
    sq_start      = 1'b0;
    unique case (state)
      S_IDLE: begin
        req.feat_addr = {node[5:0], in_feature};
        req.feat_wd   = value;
        req.feat_we   = accept && command == CMD_FEATURE && node_ok;
        req.wt_addr   = {in_feature, out_feature};
        req.wt_wd     = value;
        req.wt_we     = accept && command == CMD_WEIGHT;
        req.bias_addr = out_feature;
        req.bias_wd   = value;
        req.bias_we   = accept && command == CMD_BIAS;
        req.rp_addr   = node;
        req.rp_wd     = edge_offset;
        req.rp_we     = accept && command == CMD_ROW_PTR && node <= 7'(NODE_CAP);
        req.col_addr  = edge_position;
        req.col_wd    = neighbour;
        req.col_we    = accept && command == CMD_COL_IDX;
      end
      S_TMAC:  req.tr_we = row_done;
      S_TRP1:  req.rp_addr = 7'(node_r) + 7'd1;
      S_TRP2:  sq_start = 1'b1;
      S_TSQ:   req.inv_we = sq_done;
      S_ARP1:  req.rp_addr = 7'(node_r) + 7'd1;
      S_ACOL:  req.inv_addr = rsp.col;
      S_AMAC:  req.tr_addr = {j_r, cnt[3:0]};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      node_count <= 7'd0;
      out_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= (state == S_AOUT);
      if (cfg_valid) node_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        node_r <= node[5:0];
        cnt    <= 5'd0;
        o_cnt  <= 4'd0;
        pend   <= 1'b0;
      end
      S_TMAC, S_AMAC: begin
        if (cnt != 5'(IN_W)) cnt <= cnt + 5'd1;
        pend   <= (cnt != 5'(IN_W));
        pend_k <= cnt[3:0];
        if (state == S_TMAC && pend) acc_t <= sum_t;
        if (state == S_AMAC && pend)
          acc_a[pend_k] <= acc_a[pend_k] + 26'(signed'(prod_a[33:15]));
        if (row_done) begin
          cnt  <= 5'd0;
          pend <= 1'b0;
          if (state == S_TMAC) o_cnt <= o_cnt + 4'd1;
          else p_ptr <= p_ptr + 10'd1;
        end
      end
      S_TRP1, S_ARP1: s_ptr <= rsp.rp;
      S_ARP2: begin
        e_ptr <= rsp.rp;
        inv_i <= rsp.inv;
        p_ptr <= s_ptr;
        for (int i = 0; i < OUT_W; i++) acc_a[i] <= '0;
      end
      S_AEDGE: o_cnt <= 4'd0;
      S_ACOL:  j_r <= rsp.col;
      S_AINV:  coef <= coef_full[31:15];
      S_AOUT: begin
        out_node  <= node_r;
        out_index <= o_cnt;
        out_value <= sat16(28'(acc_a[o_cnt]));
        last      <= (o_cnt == 4'(OUT_W - 1));
        o_cnt     <= o_cnt + 4'd1;
      end
      default: ;
    endcase
  end

endmodule

/* design/graph_conv_layer.sv */
// ---------------------------------------------------------------------------
// graph_conv_layer
// one graph convolution layer over a compressed sparse row graph
// ---------------------------------------------------------------------------
// Load commands (feature, weight, bias, row pointer, column index) leave busy
// low. A transform holds busy while it computes each of the 16 outputs as a
// 16-step multiply-accumulate over the single read port of the feature and
// weight memories, then makes two row pointer reads and a bit-serial inverse
// root. In an aggregate, each edge costs a column index read, a norm read and
// a pass through the transformed row memory port; then the 16 results leave
// on consecutive cycles with out_valid high, the last marked. Results cannot
// be stalled. node_count is written through cfg_valid/cfg_data (cfg_ready is
// always high); the user must do so only while the block is idle, which the
// block itself does not enforce.
module graph_conv_layer (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [6:0]  node,
  input  logic [3:0]  in_feature,
  input  logic [3:0]  out_feature,
  input  logic [15:0] value,
  input  logic [8:0]  edge_position,
  input  logic [5:0]  neighbour,
  input  logic [9:0]  edge_offset,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  output logic        out_valid,
  output logic [5:0]  out_node,
  output logic [3:0]  out_index,
  output logic [15:0] out_value,
  output logic        last
);
  import gcl_pkg::*;

  mem_req_t    req;
  mem_rsp_t    rsp;
  logic        sq_start, sq_done;
  logic [9:0]  sq_deg;
  logic [15:0] sq_root;

  assign cfg_ready = 1'b1;

  gcl_store u_store (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

  gcl_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .deg   (sq_deg),
    .done  (sq_done),
    .root  (sq_root)
  );

  gcl_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .node          (node),
    .in_feature    (in_feature),
    .out_feature   (out_feature),
    .value         (value),
    .edge_position (edge_position),
    .neighbour     (neighbour),
    .edge_offset   (edge_offset),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .req           (req),
    .rsp           (rsp),
    .sq_start      (sq_start),
    .sq_deg        (sq_deg),
    .sq_done       (sq_done),
    .sq_root       (sq_root),
    .out_valid     (out_valid),
    .out_node      (out_node),
    .out_index     (out_index),
    .out_value     (out_value),
    .last          (last)
  );

endmodule

/* design/gcl_check.sv */
// ---------------------------------------------------------------------------
// gcl_check
// port-level checks on the result burst of the graph convolution layer
// ---------------------------------------------------------------------------
`include "graph_conv_layer_macros.svh"

module gcl_check (
  input logic       clk,
  input logic       rst,
  input logic       busy,
  input logic       out_valid,
  input logic [3:0] out_index,
  input logic       last
);

  // a result row is one unbroken burst in feature order
  `GCL_ASSERT_NXT(burst_cont, rst, out_valid && !last, out_valid)
  `GCL_ASSERT_NXT(burst_order, rst, out_valid && !last, out_index == 4'($past(out_index) + 4'd1))
  `GCL_ASSERT_IMP(last_pos, rst, out_valid && last, out_index == 4'd15)
  `GCL_ASSERT_IMP(busy_in_burst, rst, out_valid && !last, busy)
  `GCL_ASSERT_ALW(reset_quiet, rst, !out_valid)

endmodule

bind graph_conv_layer gcl_check u_gcl_check (
  .clk       (clk),
  .rst       (rst),
  .busy      (busy),
  .out_valid (out_valid),
  .out_index (out_index),
  .last      (last)
);
